>>> sv/wsd_pkg.sv
// shared types and constants of the windowed spike detector
package wsd_pkg;

	// configuration register widths and reset values
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 13;
	localparam int ITV_W     = 13;
	localparam int LOW_W     = 8;
	localparam int LVL_W     = 10;
	localparam int LIMIT_W   = 8;

	localparam logic [ITV_W-1:0]   ITV_RESET   = 13'd50;
	localparam logic [LOW_W-1:0]   LOW_RESET   = 8'd3;
	localparam logic [LVL_W-1:0]   HIGH_RESET  = 10'd33;
	localparam logic [LVL_W-1:0]   PAIR_RESET  = 10'd13;
	localparam logic [LVL_W-1:0]   GUARD_RESET = 10'd9;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd200;

	// field and state widths
	localparam int TIME_W     = 32;
	localparam int IDX_W      = 32;
	localparam int CAND_W     = IDX_W + 2;
	localparam int SUM_W      = 40;
	localparam int REJ_W      = 32;
	localparam int TALLY_W    = 8;
	localparam int RATIO_W    = 48;
	localparam int EVENT_W    = 2;
	localparam int DIVIDEND_W = 47;
	localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

	// window geometry
	localparam int WIN_DEPTH   = 6;
	localparam int JUDGE_LAG   = 3;
	localparam int FLUSH_STEPS = 3;
	localparam int SKIP_SPIKE  = 2;

	// 100 percent in Q8
	localparam int RATIO_SCALE = 25600;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SECTOR_INTERVAL = 3'd0,
		REG_LOW_LEVEL       = 3'd1,
		REG_HIGH_LEVEL      = 3'd2,
		REG_PAIR_LEVEL      = 3'd3,
		REG_GUARD_LEVEL     = 3'd4,
		REG_EVENT_LIMIT     = 3'd5
	} wsd_reg_t;

	typedef enum logic [EVENT_W-1:0] {
		EV_INCREASE = 2'd0,
		EV_DECREASE = 2'd1,
		EV_SUMMARY  = 2'd2
	} wsd_event_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FLUSH,
		S_MUL,
		S_JUDGE,
		S_RMUL,
		S_DIV,
		S_SUM
	} wsd_state_t;

	typedef struct packed {
		logic accept;
		logic flush;
		logic mul;
		logic commit;
		logic rmul;
		logic div_step;
		logic summary;
	} wsd_cmd_t;

	typedef struct packed {
		logic judge_now;
		logic flush_judge;
		logic flush_final;
		logic last;
		logic k_full;
		logic emit_req;
		logic out_free;
		logic div_last;
	} wsd_sts_t;

endpackage

>>> sv/wsd_if.sv
// request channels of the spike detector: sample input and result output
interface wsd_in_if #(
	parameter int SAMPLE_WIDTH = 16
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] variation;
	logic [wsd_pkg::TIME_W-1:0]     timing;
	logic                           last;

	modport source (output valid, output variation, output timing, output last, input ready);
	modport sink (input valid, input variation, input timing, input last, output ready);
endinterface

interface wsd_out_if #(
	parameter int SECTOR_WIDTH = 32
);
	logic                               valid;
	logic                               ready;
	logic [wsd_pkg::EVENT_W-1:0]        event_res;
	logic [SECTOR_WIDTH-1:0]            sector;
	logic [wsd_pkg::SUM_W-1:0]          magnitude_sum;
	logic [wsd_pkg::REJ_W-1:0]          rejected_count;
	logic [wsd_pkg::TALLY_W-1:0]        increase_count;
	logic [wsd_pkg::TALLY_W-1:0]        decrease_count;
	logic signed [wsd_pkg::RATIO_W-1:0] ratio_q8;
	logic                               overflow;
	logic                               final_res;

	modport source (output valid, output event_res, output sector, output magnitude_sum,
		output rejected_count, output increase_count, output decrease_count,
		output ratio_q8, output overflow, output final_res, input ready);
	modport sink (input valid, input event_res, input sector, input magnitude_sum,
		input rejected_count, input increase_count, input decrease_count,
		input ratio_q8, input overflow, input final_res, output ready);
endinterface

>>> sv/wsd_ctrl.sv
// controller state machine of the spike detector
module wsd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_last,
	input  wsd_pkg::wsd_sts_t sts,
	output logic              in_ready,
	output wsd_pkg::wsd_cmd_t cmd
);

	wsd_pkg::wsd_state_t state_q, state_d;
	logic                accept;
	logic                commit_ok;

	assign accept    = in_valid && (state_q == wsd_pkg::S_IDLE);
	assign commit_ok = !sts.emit_req || sts.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wsd_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			wsd_pkg::S_IDLE: begin
				if (accept) begin
					if (sts.judge_now) begin
						state_d = wsd_pkg::S_MUL;
					end else if (in_last) begin
						state_d = wsd_pkg::S_FLUSH;
					end
				end
			end
			wsd_pkg::S_FLUSH: begin
				if (sts.flush_judge) begin
					state_d = wsd_pkg::S_MUL;
				end else if (sts.flush_final) begin
					state_d = wsd_pkg::S_RMUL;
				end
			end
			wsd_pkg::S_MUL: begin
				state_d = wsd_pkg::S_JUDGE;
			end
			wsd_pkg::S_JUDGE: begin
				if (commit_ok) begin
					if (!sts.last) begin
						state_d = wsd_pkg::S_IDLE;
					end else if (sts.k_full) begin
						state_d = wsd_pkg::S_RMUL;
					end else begin
						state_d = wsd_pkg::S_FLUSH;
					end
				end
			end
			wsd_pkg::S_RMUL: begin
				state_d = wsd_pkg::S_DIV;
			end
			wsd_pkg::S_DIV: begin
				if (sts.div_last) begin
					state_d = wsd_pkg::S_SUM;
				end
			end
			wsd_pkg::S_SUM: begin
				if (sts.out_free) begin
					state_d = wsd_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = wsd_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		cmd          = '0;
		case (state_q)
			wsd_pkg::S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = accept;
			end
			wsd_pkg::S_FLUSH: begin
				cmd.flush = 1'b1;
			end
			wsd_pkg::S_MUL: begin
				cmd.mul = 1'b1;
			end
			wsd_pkg::S_JUDGE: begin
				cmd.commit = commit_ok;
			end
			wsd_pkg::S_RMUL: begin
				cmd.rmul = 1'b1;
			end
			wsd_pkg::S_DIV: begin
				cmd.div_step = 1'b1;
			end
			wsd_pkg::S_SUM: begin
				cmd.summary = sts.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

>>> sv/wsd_datapath.sv
// datapath: config registers, sample window, judge logic, tallies, divider, result register
module wsd_datapath #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int SECTOR_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  wsd_pkg::wsd_cmd_t                  cmd,
	output wsd_pkg::wsd_sts_t                  sts,
	input  logic signed [SAMPLE_WIDTH-1:0]     in_variation,
	input  logic [wsd_pkg::TIME_W-1:0]         in_timing,
	input  logic                               in_last,
	input  logic                               cfg_we,
	input  logic [wsd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [wsd_pkg::CFG_W-1:0]          cfg_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [wsd_pkg::EVENT_W-1:0]        out_event_res,
	output logic [SECTOR_WIDTH-1:0]            out_sector,
	output logic [wsd_pkg::SUM_W-1:0]          out_magnitude_sum,
	output logic [wsd_pkg::REJ_W-1:0]          out_rejected_count,
	output logic [wsd_pkg::TALLY_W-1:0]        out_increase_count,
	output logic [wsd_pkg::TALLY_W-1:0]        out_decrease_count,
	output logic signed [wsd_pkg::RATIO_W-1:0] out_ratio_q8,
	output logic                               out_overflow,
	output logic                               out_final_res
);

	// judge arithmetic width: room for a pair sum and for negated levels
	localparam int JW   = ((SAMPLE_WIDTH > wsd_pkg::LVL_W) ? SAMPLE_WIDTH : wsd_pkg::LVL_W) + 2;
	localparam int PW   = wsd_pkg::CAND_W + wsd_pkg::ITV_W;
	localparam int MAGW = SAMPLE_WIDTH + 1;

	// configuration
	logic [wsd_pkg::ITV_W-1:0]   itv_q;
	logic [wsd_pkg::LOW_W-1:0]   low_q;
	logic [wsd_pkg::LVL_W-1:0]   high_q;
	logic [wsd_pkg::LVL_W-1:0]   pair_q;
	logic [wsd_pkg::LVL_W-1:0]   guard_q;
	logic [wsd_pkg::LIMIT_W-1:0] limit_q;

	// run state
	logic signed [SAMPLE_WIDTH-1:0] win_q [wsd_pkg::WIN_DEPTH];
	logic [1:0]                     skip_q;
	logic [wsd_pkg::IDX_W-1:0]      sample_index_q;
	logic [wsd_pkg::SUM_W-1:0]      sum_q;
	logic [wsd_pkg::REJ_W-1:0]      reject_q;
	logic [wsd_pkg::TALLY_W-1:0]    inc_q;
	logic [wsd_pkg::TALLY_W-1:0]    dec_q;
	logic [wsd_pkg::TIME_W-1:0]     first_q;
	logic [wsd_pkg::TIME_W-1:0]     latest_q;
	logic                           dropped_q;

	// per-item control
	logic [wsd_pkg::IDX_W-1:0] idx_q;
	logic [1:0]                k_q;
	logic                      last_q;
	logic                      out_valid_q;

	// payload registers
	logic [SECTOR_WIDTH-1:0]           sector_s1;
	logic [wsd_pkg::DIVIDEND_W-1:0]    quo_q;
	logic [wsd_pkg::SUM_W:0]           rem_q;
	logic [wsd_pkg::DIV_CNT_W-1:0]     div_cnt_q;
	logic                              neg_q;

	logic [wsd_pkg::EVENT_W-1:0]        ev_q;
	logic [SECTOR_WIDTH-1:0]            osec_q;
	logic [wsd_pkg::SUM_W-1:0]          osum_q;
	logic [wsd_pkg::REJ_W-1:0]          orej_q;
	logic [wsd_pkg::TALLY_W-1:0]        oinc_q;
	logic [wsd_pkg::TALLY_W-1:0]        odec_q;
	logic signed [wsd_pkg::RATIO_W-1:0] oratio_q;
	logic                               oovf_q;
	logic                               ofinal_q;

	// judge signals
	logic signed [JW-1:0] e_m2, e_m1, e_v, e_p1, e_p2, e_p3;
	logic signed [JW-1:0] lo_x, hi_x, pr_x, gd_x;
	logic                 skip_active;
	logic                 inc_hit, inc_bad, dec_hit, dec_bad;
	logic                 inc_ok, dec_ok, inc_full, dec_full;
	logic                 emit_inc, emit_dec, do_reject, add_mag;
	logic                 dec_n1, dec_n2;
	logic [SECTOR_WIDTH-1:0]     dec_sector;
	logic [MAGW-1:0]             mag_v;
	logic [wsd_pkg::SUM_W:0]     sum_wide;
	logic [wsd_pkg::SUM_W-1:0]   sum_sat;

	logic [wsd_pkg::CAND_W-1:0]     cand1;
	logic [wsd_pkg::CAND_W-1:0]     idx_next_k;
	logic [PW-1:0]                  prod_s;
	logic                           t_neg;
	logic [wsd_pkg::TIME_W-1:0]     absd;
	logic [wsd_pkg::DIVIDEND_W-1:0] dividend;
	logic [wsd_pkg::SUM_W:0]        trial;
	logic                           trial_ge;
	logic signed [wsd_pkg::RATIO_W-1:0] ratio_v;
	logic                           out_free;
	logic                           out_load;

	// window taps, widened for the level tests
	assign e_m2 = JW'(win_q[0]);
	assign e_m1 = JW'(win_q[1]);
	assign e_v  = JW'(win_q[2]);
	assign e_p1 = JW'(win_q[3]);
	assign e_p2 = JW'(win_q[4]);
	assign e_p3 = JW'(win_q[5]);
	assign lo_x = JW'({1'b0, low_q});
	assign hi_x = JW'({1'b0, high_q});
	assign pr_x = JW'({1'b0, pair_q});
	assign gd_x = JW'({1'b0, guard_q});

	assign skip_active = (skip_q != 2'd0);
	assign inc_hit = (e_v > lo_x) && (e_v < hi_x) && ((e_v + e_p1) > pr_x);
	assign inc_bad = ((e_m2 + e_m1) < -gd_x) || ((e_p2 + e_p3) < -gd_x) || (e_m1 > gd_x);
	assign dec_hit = (e_v < -lo_x) && (e_v > -hi_x) && ((e_v + e_p1) < -pr_x);
	assign dec_bad = ((e_m2 + e_m1) > gd_x) || ((e_p2 + e_p3) > gd_x) || (e_m1 < -gd_x);

	assign inc_ok    = !skip_active && inc_hit && !inc_bad;
	assign dec_ok    = !skip_active && !inc_hit && dec_hit && !dec_bad;
	assign inc_full  = (inc_q >= limit_q);
	assign dec_full  = (dec_q >= limit_q);
	assign emit_inc  = inc_ok && !inc_full;
	assign emit_dec  = dec_ok && !dec_full;
	assign do_reject = !skip_active && ((inc_hit && inc_bad) || (!inc_hit && dec_hit && dec_bad));
	assign add_mag   = do_reject || (!skip_active && !inc_hit && !dec_hit);

	// decrease sector moves forward over trailing negatives
	assign dec_n1 = (e_p1 < -lo_x);
	assign dec_n2 = dec_n1 && (e_p2 < -lo_x);
	always_comb begin
		dec_sector = sector_s1;
		if (dec_n1) begin
			dec_sector = dec_sector + SECTOR_WIDTH'(itv_q);
		end
		if (dec_n2) begin
			dec_sector = dec_sector + SECTOR_WIDTH'(itv_q);
		end
	end

	assign mag_v    = MAGW'((e_v < 0) ? -e_v : e_v);
	assign sum_wide = {1'b0, sum_q} + (wsd_pkg::SUM_W + 1)'(mag_v);
	assign sum_sat  = sum_wide[wsd_pkg::SUM_W] ? '1 : sum_wide[wsd_pkg::SUM_W-1:0];

	// candidate position plus one, and its sector product
	assign cand1      = {2'b00, idx_q} + wsd_pkg::CAND_W'(k_q) - wsd_pkg::CAND_W'(2);
	assign idx_next_k = {2'b00, idx_q} + wsd_pkg::CAND_W'(k_q) + wsd_pkg::CAND_W'(1);
	assign prod_s     = PW'(cand1) * PW'(itv_q);

	// ratio dividend and restoring divider step
	assign t_neg    = (latest_q > first_q);
	assign absd     = t_neg ? (latest_q - first_q) : (first_q - latest_q);
	assign dividend = wsd_pkg::DIVIDEND_W'(absd) * wsd_pkg::DIVIDEND_W'(wsd_pkg::RATIO_SCALE);
	assign trial    = {rem_q[wsd_pkg::SUM_W-1:0], quo_q[wsd_pkg::DIVIDEND_W-1]};
	assign trial_ge = (trial >= {1'b0, sum_q});
	always_comb begin
		if (sum_q == '0) begin
			ratio_v = '0;
		end else if (neg_q) begin
			ratio_v = -wsd_pkg::RATIO_W'(quo_q);
		end else begin
			ratio_v = wsd_pkg::RATIO_W'(quo_q);
		end
	end

	assign out_free = !out_valid_q || out_ready;
	assign out_load = (cmd.commit && (emit_inc || emit_dec)) || cmd.summary;

	always_comb begin
		sts             = '0;
		sts.judge_now   = (sample_index_q >= wsd_pkg::IDX_W'(wsd_pkg::JUDGE_LAG));
		sts.flush_judge = (idx_next_k >= wsd_pkg::CAND_W'(wsd_pkg::JUDGE_LAG));
		sts.flush_final = (k_q == 2'(wsd_pkg::FLUSH_STEPS - 1));
		sts.last        = last_q;
		sts.k_full      = (k_q == 2'(wsd_pkg::FLUSH_STEPS));
		sts.emit_req    = emit_inc || emit_dec;
		sts.out_free    = out_free;
		sts.div_last    = (div_cnt_q == wsd_pkg::DIV_CNT_W'(wsd_pkg::DIVIDEND_W - 1));
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			itv_q   <= wsd_pkg::ITV_RESET;
			low_q   <= wsd_pkg::LOW_RESET;
			high_q  <= wsd_pkg::HIGH_RESET;
			pair_q  <= wsd_pkg::PAIR_RESET;
			guard_q <= wsd_pkg::GUARD_RESET;
			limit_q <= wsd_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				wsd_pkg::REG_SECTOR_INTERVAL: itv_q   <= cfg_data[wsd_pkg::ITV_W-1:0];
				wsd_pkg::REG_LOW_LEVEL:       low_q   <= cfg_data[wsd_pkg::LOW_W-1:0];
				wsd_pkg::REG_HIGH_LEVEL:      high_q  <= cfg_data[wsd_pkg::LVL_W-1:0];
				wsd_pkg::REG_PAIR_LEVEL:      pair_q  <= cfg_data[wsd_pkg::LVL_W-1:0];
				wsd_pkg::REG_GUARD_LEVEL:     guard_q <= cfg_data[wsd_pkg::LVL_W-1:0];
				wsd_pkg::REG_EVENT_LIMIT:     limit_q <= cfg_data[wsd_pkg::LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// run state, cleared after the summary
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < wsd_pkg::WIN_DEPTH; i++) begin
				win_q[i] <= '0;
			end
			skip_q         <= '0;
			sample_index_q <= '0;
			sum_q          <= '0;
			reject_q       <= '0;
			inc_q          <= '0;
			dec_q          <= '0;
			first_q        <= '0;
			latest_q       <= '0;
			dropped_q      <= 1'b0;
			idx_q          <= '0;
			k_q            <= '0;
			last_q         <= 1'b0;
		end else begin
			if (cmd.accept) begin
				for (int i = 0; i < wsd_pkg::WIN_DEPTH - 1; i++) begin
					win_q[i] <= win_q[i+1];
				end
				win_q[wsd_pkg::WIN_DEPTH-1] <= in_variation;
				if (sample_index_q == '0) begin
					first_q <= in_timing;
				end
				latest_q <= in_timing;
				if (sample_index_q != '1) begin
					sample_index_q <= sample_index_q + 1'b1;
				end
				idx_q  <= sample_index_q;
				k_q    <= '0;
				last_q <= in_last;
			end
			if (cmd.flush) begin
				for (int i = 0; i < wsd_pkg::WIN_DEPTH - 1; i++) begin
					win_q[i] <= win_q[i+1];
				end
				win_q[wsd_pkg::WIN_DEPTH-1] <= '0;
				k_q <= k_q + 2'd1;
			end
			if (cmd.commit) begin
				if (skip_active) begin
					skip_q <= skip_q - 2'd1;
				end
				if (inc_ok || dec_ok) begin
					skip_q <= 2'(wsd_pkg::SKIP_SPIKE);
				end
				if ((inc_ok && inc_full) || (dec_ok && dec_full)) begin
					dropped_q <= 1'b1;
				end
				if (emit_inc) begin
					inc_q <= inc_q + 1'b1;
				end
				if (emit_dec) begin
					dec_q <= dec_q + 1'b1;
				end
				if (do_reject && (reject_q != '1)) begin
					reject_q <= reject_q + 1'b1;
				end
				if (add_mag) begin
					sum_q <= sum_sat;
				end
			end
			if (cmd.summary) begin
				for (int i = 0; i < wsd_pkg::WIN_DEPTH; i++) begin
					win_q[i] <= '0;
				end
				skip_q         <= '0;
				sample_index_q <= '0;
				sum_q          <= '0;
				reject_q       <= '0;
				inc_q          <= '0;
				dec_q          <= '0;
				first_q        <= '0;
				latest_q       <= '0;
				dropped_q      <= 1'b0;
				last_q         <= 1'b0;
			end
		end
	end

	// sector product and ratio divider
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			sector_s1 <= SECTOR_WIDTH'(prod_s);
		end
		if (cmd.rmul) begin
			quo_q     <= dividend;
			rem_q     <= '0;
			div_cnt_q <= '0;
			neg_q     <= t_neg;
		end
		if (cmd.div_step) begin
			quo_q     <= {quo_q[wsd_pkg::DIVIDEND_W-2:0], trial_ge};
			rem_q     <= trial_ge ? (trial - {1'b0, sum_q}) : trial;
			div_cnt_q <= div_cnt_q + 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (cmd.summary) begin
				ev_q     <= wsd_pkg::EV_SUMMARY;
				osec_q   <= '0;
				osum_q   <= sum_q;
				orej_q   <= reject_q;
				oinc_q   <= inc_q;
				odec_q   <= dec_q;
				oratio_q <= ratio_v;
				oovf_q   <= dropped_q;
				ofinal_q <= 1'b1;
			end else begin
				ev_q     <= emit_inc ? wsd_pkg::EV_INCREASE : wsd_pkg::EV_DECREASE;
				osec_q   <= emit_inc ? sector_s1 : dec_sector;
				osum_q   <= '0;
				orej_q   <= '0;
				oinc_q   <= '0;
				odec_q   <= '0;
				oratio_q <= '0;
				oovf_q   <= 1'b0;
				ofinal_q <= 1'b0;
			end
		end
	end

	assign out_valid          = out_valid_q;
	assign out_event_res      = ev_q;
	assign out_sector         = osec_q;
	assign out_magnitude_sum  = osum_q;
	assign out_rejected_count = orej_q;
	assign out_increase_count = oinc_q;
	assign out_decrease_count = odec_q;
	assign out_ratio_q8       = oratio_q;
	assign out_overflow       = oovf_q;
	assign out_final_res      = ofinal_q;

endmodule

>>> sv/windowed_spike_detector_core.sv
// top level of the windowed spike detector
//
//  port     | dir | handshake         | carries
//  ---------+-----+-------------------+------------------------------------------
//  in_ch    | in  | valid/ready       | variation, timing, last
//  out_ch   | out | valid/ready       | event_res, sector, summary fields, final_res
//  cfg_*    | in  | cfg_we, no stall  | cfg_index selects register, cfg_data value
//
// a sample whose candidate is not yet judged is only accepted; otherwise it passes through
// accept, sector multiply, judge and commit to the result register
// the last sample adds up to three flush steps, then the ratio
// dividend, the one-bit-per-cycle divider and the summary
// a full result register stalls the judge or summary step until out_ch takes it
// arst_n loads register defaults and clears run state; no clearing pass is needed
module windowed_spike_detector_core #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int SECTOR_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	wsd_in_if.sink                        in_ch,
	wsd_out_if.source                     out_ch,
	input  logic                          cfg_we,
	input  logic [wsd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wsd_pkg::CFG_W-1:0]     cfg_data
);

	wsd_pkg::wsd_cmd_t cmd;
	wsd_pkg::wsd_sts_t sts;

	wsd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_last  (in_ch.last),
		.sts      (sts),
		.in_ready (in_ch.ready),
		.cmd      (cmd)
	);

	wsd_datapath #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.SECTOR_WIDTH (SECTOR_WIDTH)
	) u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.in_variation       (in_ch.variation),
		.in_timing          (in_ch.timing),
		.in_last            (in_ch.last),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.out_valid          (out_ch.valid),
		.out_ready          (out_ch.ready),
		.out_event_res      (out_ch.event_res),
		.out_sector         (out_ch.sector),
		.out_magnitude_sum  (out_ch.magnitude_sum),
		.out_rejected_count (out_ch.rejected_count),
		.out_increase_count (out_ch.increase_count),
		.out_decrease_count (out_ch.decrease_count),
		.out_ratio_q8       (out_ch.ratio_q8),
		.out_overflow       (out_ch.overflow),
		.out_final_res      (out_ch.final_res)
	);

endmodule
